FILE: design/cascaded_biquad_iir_filter_core_assert.svh
// Assertion macros shared by the biquad cascade modules.
`ifndef CASCADED_BIQUAD_IIR_FILTER_CORE_ASSERT_SVH
`define CASCADED_BIQUAD_IIR_FILTER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Antecedent true implies consequent in the same cycle.
`define CBIQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Antecedent true implies consequent in the next cycle.
`define CBIQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CBIQ_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define CBIQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: design/cbiq_pkg.sv
// Types and constants of the cascaded biquad filter.
`timescale 1ns / 1ps
`default_nettype none
package cbiq_pkg;
    localparam int SECTIONS    = 16;
    localparam int CHANNELS    = 2;
    localparam int SAMPLE_BITS = 24;
    localparam int COEF_BITS   = 24;
    localparam int NCOEF       = 5;
    localparam int FRAC_C      = COEF_BITS - 4;
    localparam int PROD_W      = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_EXT     = 3;
    localparam int ACC_W       = PROD_W + ACC_EXT;
    localparam int SEC_IDX_W   = 4;
    localparam int SEL_W       = 3;
    localparam int CNT_W       = $clog2(SECTIONS + 1);
    localparam int CFG_W       = 5;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    localparam logic [SEL_W-1:0] SEL_B0 = 3'd0;
    localparam logic [SEL_W-1:0] SEL_B1 = 3'd1;
    localparam logic [SEL_W-1:0] SEL_B2 = 3'd2;
    localparam logic [SEL_W-1:0] SEL_A1 = 3'd3;
    localparam logic [SEL_W-1:0] SEL_A2 = 3'd4;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_COEF   = 1'b1;

    localparam logic REG_ACTIVE = 1'b0;

    typedef struct packed {
        logic                          cmd;
        logic                          channel;
        logic signed [SAMPLE_BITS-1:0] in_sample;
        logic [SEC_IDX_W-1:0]          coef_section;
        logic [SEL_W-1:0]              coef_select;
        logic signed [COEF_BITS-1:0]   coef_value;
    } t_in_item;

    typedef struct packed {
        logic                          out_channel;
        logic signed [SAMPLE_BITS-1:0] out_sample;
    } t_out_item;

    // Sample moving along the cell row; rem counts sections still to apply.
    typedef struct packed {
        logic                          vld;
        logic                          ch;
        logic signed [SAMPLE_BITS-1:0] data;
        logic [CNT_W-1:0]              rem;
    } t_link;

    typedef struct packed {
        logic                        en;
        logic [SEC_IDX_W-1:0]        sec;
        logic [SEL_W-1:0]            sel;
        logic signed [COEF_BITS-1:0] value;
    } t_coef_wr;
endpackage
`default_nettype wire

FILE: design/cbiq_cell.sv
// One biquad section: coefficients, per-channel histories and a pipelined MAC.
`timescale 1ns / 1ps
`default_nettype none
`include "cascaded_biquad_iir_filter_core_assert.svh"
module cbiq_cell (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire [cbiq_pkg::SEC_IDX_W-1:0]   i_index,
    input  cbiq_pkg::t_coef_wr              i_coef_wr,
    input  cbiq_pkg::t_link                 i_link,
    output cbiq_pkg::t_link                 o_link
);
    import cbiq_pkg::*;

    localparam logic signed [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1) <<< FRAC_C;
    localparam logic signed [ACC_W-1:0] ROUND_W = ACC_W'(1) <<< (FRAC_C - 1);
    localparam logic signed [ACC_W-1:0] SMAX_W  = (ACC_W'(1) <<< (SAMPLE_BITS - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] SMIN_W  = -SMAX_W - ACC_W'(1);

    logic signed [COEF_BITS-1:0]   r_coef [NCOEF];
    logic signed [SAMPLE_BITS-1:0] r_x1 [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] r_x2 [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] r_y1 [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] r_y2 [CHANNELS];
    logic signed [PROD_W-1:0]      r_p [NCOEF];
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic                          r_ch;
    logic [CNT_W-1:0]              r_rem;
    logic                          r_v1;
    t_link                         r_out;

    logic                          w_take;
    logic signed [ACC_W-1:0]       w_ext [NCOEF];
    logic signed [ACC_W-1:0]       w_sum;
    logic signed [ACC_W-1:0]       w_q;
    logic signed [SAMPLE_BITS-1:0] w_y;

    assign w_take = i_link.vld && (i_link.rem != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < NCOEF; j++) begin
                r_coef[j] <= (j == int'(SEL_B0)) ? COEF_ONE : '0;
            end
        end else if (i_coef_wr.en && (i_coef_wr.sec == i_index)
                     && (int'(i_coef_wr.sel) < NCOEF)) begin
            r_coef[i_coef_wr.sel] <= i_coef_wr.value;
        end
    end

    // Stage one: five products in parallel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= w_take;
        end
        if (w_take) begin
            r_p[SEL_B0] <= r_coef[SEL_B0] * i_link.data;
            r_p[SEL_B1] <= r_coef[SEL_B1] * r_x1[i_link.ch];
            r_p[SEL_B2] <= r_coef[SEL_B2] * r_x2[i_link.ch];
            r_p[SEL_A1] <= r_coef[SEL_A1] * r_y1[i_link.ch];
            r_p[SEL_A2] <= r_coef[SEL_A2] * r_y2[i_link.ch];
            r_x         <= i_link.data;
            r_ch        <= i_link.ch;
            r_rem       <= i_link.rem - CNT_W'(1);
        end
    end

    // Stage two: sum, round half up, saturate.
    always_comb begin
        for (int j = 0; j < NCOEF; j++) begin
            w_ext[j] = $signed({{ACC_EXT{r_p[j][PROD_W-1]}}, r_p[j]});
        end
        w_sum = w_ext[SEL_B0] + w_ext[SEL_B1] + w_ext[SEL_B2]
              - w_ext[SEL_A1] - w_ext[SEL_A2] + ROUND_W;
        w_q   = w_sum >>> FRAC_C;
        if (w_q > SMAX_W) begin
            w_y = SMAX_W[SAMPLE_BITS-1:0];
        end else if (w_q < SMIN_W) begin
            w_y = SMIN_W[SAMPLE_BITS-1:0];
        end else begin
            w_y = w_q[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_x1[c] <= '0;
                r_x2[c] <= '0;
                r_y1[c] <= '0;
                r_y2[c] <= '0;
            end
        end else if (r_v1) begin
            r_x2[r_ch] <= r_x1[r_ch];
            r_x1[r_ch] <= r_x;
            r_y2[r_ch] <= r_y1[r_ch];
            r_y1[r_ch] <= w_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.vld <= 1'b0;
        end else begin
            r_out.vld <= r_v1;
        end
        if (r_v1) begin
            r_out.ch   <= r_ch;
            r_out.data <= w_y;
            r_out.rem  <= r_rem;
        end
    end

    assign o_link = r_out;

    `CBIQ_ASSERT_NEXT(a_take_mac, i_clk, i_rst_n, w_take, r_v1)
    `CBIQ_ASSERT_NEXT(a_mac_out, i_clk, i_rst_n, r_v1, r_out.vld && !r_v1)
    `CBIQ_ASSERT_NOW(a_one_item, i_clk, i_rst_n, r_v1, !i_link.vld && !r_out.vld)
endmodule
`default_nettype wire

FILE: design/cascaded_biquad_iir_filter_core.sv
// Top level of the cascaded direct-form-I biquad filter.
`timescale 1ns / 1ps
`default_nettype none
`include "cascaded_biquad_iir_filter_core_assert.svh"
// Cascaded biquad IIR filter, direct form I with a0 = 1, for two channels and up
// to sixteen sections. Each section is a cell in a row; a sample enters the
// first cell and each active cell computes b0*x + b1*x1 + b2*x2 - a1*y1 - a2*y2
// with five parallel multipliers into registered products, then sums, rounds
// half up and saturates in the next cycle; with no active section the result
// is 0. The block works on one sample at a time: a new transaction is taken
// once the previous result has moved to the output register. Coefficient
// writes (cmd = 1) give no result; they reset to bypass (b0 = 1.0, Q3.20).
// Register active_sections lies at APB byte address 0 (reset 1; values above
// sixteen act as sixteen). Each cell keeps its coefficients and its histories
// in flip-flops, so reset restores them at once: bypass coefficients and zero
// histories.
module cascaded_biquad_iir_filter_core (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_in_valid,
    output logic                          o_in_ready,
    input  cbiq_pkg::t_in_item            i_in_data,
    output logic                          o_out_valid,
    input  wire                           i_out_ready,
    output cbiq_pkg::t_out_item           o_out_data,
    input  wire                           i_psel,
    input  wire                           i_penable,
    input  wire                           i_pwrite,
    input  wire [cbiq_pkg::APB_AW-1:0]    i_paddr,
    input  wire [cbiq_pkg::APB_DW-1:0]    i_pwdata,
    output logic [cbiq_pkg::APB_DW-1:0]   o_prdata,
    output logic                          o_pready
);
    import cbiq_pkg::*;

    logic [CFG_W-1:0] r_act;
    logic             r_busy;
    t_link            r_inj;
    logic             r_pend_valid;
    t_out_item        r_pend;
    logic             r_out_valid;
    t_out_item        r_out;

    logic             w_in_acc;
    logic             w_smp;
    logic             w_move;
    logic [CNT_W-1:0] w_n;
    t_coef_wr         w_coef_wr;
    t_link            w_link [SECTIONS];
    logic [SECTIONS-1:0] w_done;
    t_out_item        w_done_item;

    // APB: always ready; register index from the word address.
    assign o_pready = 1'b1;
    assign o_prdata = (i_paddr[2] == REG_ACTIVE) ? APB_DW'(r_act) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= CFG_W'(1);
        end else if (i_psel && i_penable && i_pwrite && (i_paddr[2] == REG_ACTIVE)) begin
            r_act <= i_pwdata[CFG_W-1:0];
        end
    end

    // Clamp the section count to the number of cells.
    assign w_n = (int'(r_act) > SECTIONS) ? CNT_W'(SECTIONS) : CNT_W'(r_act);

    assign o_in_ready = !r_busy;
    assign w_in_acc   = i_in_valid && o_in_ready;
    // Drop samples on channels that have no history.
    assign w_smp      = w_in_acc && (i_in_data.cmd == CMD_SAMPLE)
                        && (int'(i_in_data.channel) < CHANNELS);

    // Broadcast coefficient writes to every cell; the addressed one loads.
    assign w_coef_wr.en    = w_in_acc && (i_in_data.cmd == CMD_COEF);
    assign w_coef_wr.sec   = i_in_data.coef_section;
    assign w_coef_wr.sel   = i_in_data.coef_select;
    assign w_coef_wr.value = i_in_data.coef_value;

    // Inject the sample into the first cell for one cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inj.vld <= 1'b0;
        end else begin
            r_inj.vld <= w_smp && (w_n != '0);
        end
        if (w_smp) begin
            r_inj.ch   <= i_in_data.channel;
            r_inj.data <= i_in_data.in_sample;
            r_inj.rem  <= w_n;
        end
    end

    genvar g;
    generate
        for (g = 0; g < SECTIONS; g++) begin : g_cell
            cbiq_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_index   (SEC_IDX_W'(g)),
                .i_coef_wr (w_coef_wr),
                .i_link    ((g == 0) ? r_inj : w_link[(g == 0) ? 0 : g - 1]),
                .o_link    (w_link[g])
            );
            // The cell that used up the last section carries the result.
            assign w_done[g] = w_link[g].vld && (w_link[g].rem == '0);
        end
    endgenerate

    always_comb begin
        w_done_item = '0;
        for (int k = 0; k < SECTIONS; k++) begin
            if (w_done[k]) begin
                w_done_item.out_channel = w_link[k].ch;
                w_done_item.out_sample  = w_link[k].data;
            end
        end
    end

    // Hold the finished result until the output register is free.
    assign w_move = r_pend_valid && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (w_smp && (w_n == '0)) begin
            r_pend_valid <= 1'b1;
        end else if (|w_done) begin
            r_pend_valid <= 1'b1;
        end else if (w_move) begin
            r_pend_valid <= 1'b0;
        end
        if (w_smp && (w_n == '0)) begin
            r_pend.out_channel <= i_in_data.channel;
            r_pend.out_sample  <= '0;
        end else if (|w_done) begin
            r_pend <= w_done_item;
        end
    end

    // Busy from sample acceptance until its result leaves the pending stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_smp) begin
            r_busy <= 1'b1;
        end else if (w_move) begin
            r_busy <= 1'b0;
        end
    end

    // Output register: parts the result side from the filter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_move) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_move) begin
            r_out <= r_pend;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `CBIQ_ASSERT_NEXT(a_smp_busy, i_clk, i_rst_n, w_smp, r_busy)
    `CBIQ_ASSERT_NOW(a_done_one, i_clk, i_rst_n, 1'b1, $onehot0(w_done))
    `CBIQ_ASSERT_NOW(a_pend_busy, i_clk, i_rst_n, r_pend_valid || (|w_done), r_busy)
    `CBIQ_ASSERT_NOW(a_done_free, i_clk, i_rst_n, |w_done, !r_pend_valid)
endmodule
`default_nettype wire

FILE: sim/cascaded_biquad_iir_filter_core_tb.sv
// Testbench for the cascaded biquad filter core: random transactions checked by a scoreboard.
`timescale 1ns / 1ps
`default_nettype none
module cascaded_biquad_iir_filter_core_tb;
    import cbiq_pkg::*;

    // Bit-accurate model of the filter cascade plus a queue of expected outputs.
    class biquad_scoreboard;
        logic signed [COEF_BITS-1:0]   coefs [SECTIONS][NCOEF];
        logic signed [SAMPLE_BITS-1:0] xhist [CHANNELS][SECTIONS][2];
        logic signed [SAMPLE_BITS-1:0] yhist [CHANNELS][SECTIONS][2];
        logic [CFG_W-1:0] n_active;
        t_out_item pending_q[$];
        int mismatches;
        int checked;

        function new();
            n_active = CFG_W'(1);
            mismatches = 0;
            checked = 0;
            for (int s = 0; s < SECTIONS; s++) begin
                for (int k = 0; k < NCOEF; k++) coefs[s][k] = '0;
                coefs[s][SEL_B0] = COEF_BITS'(1 << FRAC_C);
                for (int c = 0; c < CHANNELS; c++)
                    for (int j = 0; j < 2; j++) begin
                        xhist[c][s][j] = '0;
                        yhist[c][s][j] = '0;
                    end
            end
        endfunction

        // Sum the five products, round half up, saturate to the sample width.
        function automatic logic signed [SAMPLE_BITS-1:0] section_out(int ch, int s,
                logic signed [SAMPLE_BITS-1:0] x);
            logic signed [63:0] acc;
            logic signed [63:0] q;
            acc = 64'(coefs[s][SEL_B0]) * 64'(x)
                + 64'(coefs[s][SEL_B1]) * 64'(xhist[ch][s][0])
                + 64'(coefs[s][SEL_B2]) * 64'(xhist[ch][s][1])
                - 64'(coefs[s][SEL_A1]) * 64'(yhist[ch][s][0])
                - 64'(coefs[s][SEL_A2]) * 64'(yhist[ch][s][1]);
            q = (acc + (64'sd1 <<< (FRAC_C - 1))) >>> FRAC_C;
            if (q > 64'sd8388607) q = 64'sd8388607;
            if (q < -64'sd8388608) q = -64'sd8388608;
            return q[SAMPLE_BITS-1:0];
        endfunction

        function void note_input(t_in_item it);
            int n;
            logic signed [SAMPLE_BITS-1:0] x, y;
            t_out_item r;
            if (it.cmd == CMD_COEF) begin
                if (it.coef_select <= SEL_A2) coefs[it.coef_section][it.coef_select] = it.coef_value;
                return;
            end
            n = (n_active > SECTIONS) ? SECTIONS : n_active;
            x = it.in_sample;
            y = '0;
            for (int s = 0; s < n; s++) begin
                y = section_out(it.channel, s, x);
                xhist[it.channel][s][1] = xhist[it.channel][s][0];
                xhist[it.channel][s][0] = x;
                yhist[it.channel][s][1] = yhist[it.channel][s][0];
                yhist[it.channel][s][0] = y;
                x = y;
            end
            r.out_channel = it.channel;
            r.out_sample = y;
            pending_q.push_back(r);
        endfunction

        function void check_output(t_out_item got);
            t_out_item e;
            checked++;
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected output %h", got);
                return;
            end
            e = pending_q.pop_front();
            if (got.out_channel !== e.out_channel || got.out_sample !== e.out_sample) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected ch %0d sample %0d, got ch %0d sample %0d",
                             e.out_channel, e.out_sample, got.out_channel, got.out_sample);
            end
        endfunction
    endclass

    logic i_clk, i_rst_n;
    logic i_in_valid, o_in_ready, o_out_valid, i_out_ready;
    t_in_item i_in_data;
    t_out_item o_out_data;
    logic i_psel, i_penable, i_pwrite;
    logic [APB_AW-1:0] i_paddr;
    logic [APB_DW-1:0] i_pwdata, o_prdata;
    logic o_pready;

    cascaded_biquad_iir_filter_core uut (.*);

    biquad_scoreboard sb;
    longint cycles;
    int n_samples, n_coefs;
    bit sink_on;

    localparam longint CYCLE_LIMIT = 2_000_000;

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    // Abort the run if it never drains.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Output side: stall randomly, check every accepted transaction.
    initial begin
        int w;
        i_out_ready = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            w = $urandom_range(0, 8);
            if ($urandom_range(0, 3) == 0) w = 0;
            if (w > 0) begin
                i_out_ready <= 0;
                repeat (w) @(posedge i_clk);
            end
            i_out_ready <= 1;
            @(posedge i_clk iff o_out_valid);
            sb.check_output(o_out_data);
        end
    end

    // Send one transaction after a random gap; drop valid only for a gap.
    task automatic send_item(t_in_item it, int max_gap);
        int gap;
        gap = $urandom_range(0, max_gap);
        if (gap > 0) begin
            i_in_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_in_data <= it;
        @(posedge i_clk iff o_in_ready);
        sb.note_input(it);
        if (it.cmd == CMD_COEF) n_coefs++; else n_samples++;
    endtask

    // Drop valid, wait until all outputs are back, then let the pipeline settle.
    task automatic drain();
        i_in_valid <= 0;
        @(posedge i_clk iff sb.pending_q.size() == 0);
        repeat (2 * SECTIONS + 10) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
        i_psel <= 1; i_penable <= 0; i_pwrite <= 1; i_paddr <= addr; i_pwdata <= data;
        @(posedge i_clk);
        i_penable <= 1;
        @(posedge i_clk iff o_pready);
        i_psel <= 0; i_penable <= 0; i_pwrite <= 0;
        if (addr == 0) sb.n_active = data[CFG_W-1:0];
    endtask

    function automatic t_in_item rand_sample(int ch, int amp_sel);
        t_in_item it;
        it = t_in_item'($bits(t_in_item)'({$urandom, $urandom}));
        it.cmd = CMD_SAMPLE;
        it.channel = ch[0];
        if (amp_sel == 0) it.in_sample = 24'sh7fffff;
        else if (amp_sel == 1) it.in_sample = 24'sh800000;
        else if (amp_sel == 2)
            it.in_sample = 24'($signed(24'($urandom_range(0, 4095))) - 2048);
        return it;
    endfunction

    // Coefficient write; small values keep most sections stable.
    function automatic t_in_item coef_item(int sec, int sel, logic signed [23:0] v);
        t_in_item it;
        it = t_in_item'($bits(t_in_item)'({$urandom, $urandom}));
        it.cmd = CMD_COEF;
        it.coef_section = sec[3:0];
        it.coef_select = sel[2:0];
        it.coef_value = v;
        return it;
    endfunction

    function automatic logic signed [23:0] rand_coef();
        case ($urandom_range(0, 5))
            0: return 24'sh7fffff;
            1: return 24'sh800000;
            2: return 24'($urandom);
            default: return 24'($signed(24'($urandom_range(0, 1 << 20))) - (1 << 19));
        endcase
    endfunction

    initial begin
        t_in_item it;
        int cfgs[6] = '{0, 16, 31, 1, 3, 17};
        sb = new();
        cycles = 0;
        n_samples = 0;
        n_coefs = 0;
        i_rst_n = 0;
        i_in_valid = 0;
        i_in_data = '0;
        i_psel = 0; i_penable = 0; i_pwrite = 0; i_paddr = '0; i_pwdata = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: bypass extremes, zero sections, ignored writes, saturation.
        send_item(rand_sample(0, 0), 0);
        send_item(rand_sample(1, 1), 0);
        send_item(rand_sample(0, 3), 2);
        drain();
        apb_write(0, 0);
        send_item(rand_sample(0, 0), 0);
        send_item(rand_sample(1, 3), 0);
        drain();
        apb_write(0, 2);
        send_item(coef_item(0, SEL_B0, 24'sh7fffff), 0);
        send_item(coef_item(0, SEL_B1, 24'sh800000), 0);
        send_item(coef_item(0, SEL_B2, 24'sh100000), 0);
        send_item(coef_item(0, SEL_A1, 24'sh7fffff), 0);
        send_item(coef_item(1, SEL_A2, 24'sh800000), 0);
        send_item(coef_item(15, 5, 24'sh123456), 0);
        send_item(coef_item(15, 7, 24'shfedcba), 0);
        for (int k = 0; k < 6; k++) send_item(rand_sample(k & 1, k % 4), 1);
        drain();
        // Pressure: pause the sender until all outputs are back.
        @(posedge i_clk iff sb.pending_q.size() == 0);

        // Random phases over several section counts.
        foreach (cfgs[p]) begin
            drain();
            apb_write(0, cfgs[p]);
            for (int k = 0; k < 270; k++) begin
                if ($urandom_range(0, 9) == 0) begin
                    if ($urandom_range(0, 7) == 0)
                        it = coef_item($urandom_range(0, 15), $urandom_range(0, 7),
                                       24'($urandom));
                    else
                        it = coef_item($urandom_range(0, 15), $urandom_range(0, 4), rand_coef());
                end else begin
                    it = rand_sample($urandom_range(0, 1), $urandom_range(0, 9));
                end
                send_item(it, (k % 60 < 20) ? 0 : 8);
            end
        end

        drain();
        $display("ran %0d samples and %0d coefficient writes over section counts 0 to 31",
                 n_samples, n_coefs);
        $display("checked %0d outputs, %0d mismatches", sb.checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
`default_nettype wire
